/* rtl/core/pld_pkg.sv */
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types, codes and constants of the phone line state detector.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int WINDOW_SHIFT = 4;
  localparam int SAMPLE_W     = 8;
  localparam int SUM_W        = SAMPLE_W + WINDOW_SHIFT;
  localparam int IDX_W        = WINDOW_SHIFT;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int REPS_W       = 5;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SAMPLE_W-1:0] RISE_LOW     = 8'd5;
  localparam logic [SAMPLE_W-1:0] RISE_HIGH    = 8'd50;
  localparam logic [REPS_W-1:0]   REPEAT_LIMIT = 5'd20;

  typedef enum logic [2:0] {
    CODE_ONHOOK   = 3'd0,
    CODE_NOLINE   = 3'd1,
    CODE_OFFHOOK  = 3'd2,
    CODE_RINGING  = 3'd3,
    CODE_SHUTDOWN = 3'd4
  } msg_code_t;

  typedef enum logic [1:0] {
    LINE_ONHOOK  = 2'd0,
    LINE_NOLINE  = 2'd1,
    LINE_OFFHOOK = 2'd2
  } line_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONHOOK_LEVEL       = 3'd0,
    CFG_ONHOOK_PREV_LEVEL  = 3'd1,
    CFG_NOLINE_LEVEL       = 3'd2,
    CFG_OFFHOOK_UPPER      = 3'd3,
    CFG_OFFHOOK_PREV_LEVEL = 3'd4,
    CFG_SWING_HIGH         = 3'd5,
    CFG_SWING_LOW          = 3'd6,
    CFG_SHUTDOWN_AFTER     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]        onhook_level;
    logic [7:0]        onhook_prev_level;
    logic [7:0]        noline_level;
    logic [7:0]        offhook_upper;
    logic [7:0]        offhook_prev_level;
    logic [7:0]        swing_high;
    logic [7:0]        swing_low;
    logic [REPS_W-1:0] shutdown_after;
  } cfg_t;

  // one window-end record: up to two result beats
  typedef struct packed {
    logic          two;
    logic          valid0;
    msg_code_t     code0;
    logic          stop0;
    msg_code_t     code1;
    logic          stop1;
    logic          ring_up;
    logic [7:0]    avg;
  } rec_t;

  function automatic msg_code_t line_code(line_t l);
    msg_code_t c;
    c = msg_code_t'({1'b0, l});
    return c;
  endfunction

endpackage

/* rtl/core/pld_if.sv */
// ----------------------------------------------------------------------------
// pld_in_if / pld_out_if
// Valid/ready channels carrying samples in and status results out.
// ----------------------------------------------------------------------------
interface pld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       line_pin;
  logic       resend_request;

  modport source (output valid, output sample, output line_pin, output resend_request,
                  input ready);
  modport sink   (input valid, input sample, input line_pin, input resend_request,
                  output ready);
endinterface

interface pld_out_if;
  logic       valid;
  logic       ready;
  logic       msg_valid;
  logic [2:0] msg_code;
  logic       voice_stop;
  logic       ring_up;
  logic [7:0] window_average;
  logic       last;

  modport source (output valid, output msg_valid, output msg_code, output voice_stop,
                  output ring_up, output window_average, output last, input ready);
  modport sink   (input valid, input msg_valid, input msg_code, input voice_stop,
                  input ring_up, input window_average, input last, output ready);
endinterface

/* rtl/core/pld_front.sv */
// ----------------------------------------------------------------------------
// pld_front
// Accumulates sample windows, tracks ring-up and classifies the line at
// each window end into a record of up to two result beats.
// ----------------------------------------------------------------------------
module pld_front (
  input  logic          clk,
  input  logic          rst_n,
  pld_in_if.sink        in_bus,
  input  pld_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          q_push,
  output pld_pkg::rec_t q_rec
);
  import pld_pkg::*;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_c;
  logic              low_r, low_nxt, low_c;
  logic [1:0]        rise_r, rise_nxt, rise_c;
  logic [7:0]        prev_avg_r, prev_avg_nxt;
  line_t             line_r, line_nxt, line_c;
  line_t             prev_line_r, prev_line_nxt;
  logic [REPS_W-1:0] reps_r, reps_nxt, reps_c;
  logic              rung_r, rung_nxt;
  logic              resend_r, resend_nxt;

  logic       acc, wend, resend_c, ring_c, swing;
  logic [7:0] avg_c, s;
  logic       rep1, rep2;
  msg_code_t  code1;
  logic       stop2;
  msg_code_t  code2;

  assign in_bus.ready = !q_full;
  assign acc  = in_bus.valid && !q_full;
  assign s    = in_bus.sample;
  assign wend = (idx_r == {IDX_W{1'b1}});

  always_comb begin
    resend_c = resend_r | in_bus.resend_request;
    low_c  = low_r;
    rise_c = rise_r;
    if (s < RISE_LOW) begin
      low_c = 1'b1;
    end else if (low_r && (s > RISE_HIGH)) begin
      if (rise_r < 2'd2) rise_c = rise_r + 2'd1;
      low_c = 1'b0;
    end
    sum_c  = sum_r + {{WINDOW_SHIFT{1'b0}}, s};
    avg_c  = sum_c[SUM_W-1:WINDOW_SHIFT];
    ring_c = (rise_c >= 2'd2);
    swing  = ((prev_avg_r > cfg.swing_high) && (avg_c < cfg.swing_low)) ||
             ((prev_avg_r < cfg.swing_low) && (avg_c > cfg.swing_high));
    reps_c = swing ? '0 : reps_r;
    line_c = line_r;
    if (in_bus.line_pin) begin
      if ((avg_c > cfg.onhook_level) && (prev_avg_r > cfg.onhook_prev_level)) begin
        line_c = LINE_ONHOOK;
      end else if (avg_c < cfg.noline_level) begin
        reps_c = '0;
        if (prev_line_r != LINE_ONHOOK) line_c = LINE_NOLINE;
      end else if ((avg_c < cfg.offhook_upper) &&
                   (prev_avg_r > cfg.offhook_prev_level)) begin
        line_c = LINE_OFFHOOK;
        reps_c = '0;
      end
    end else begin
      reps_c = '0;
    end

    rep1  = (line_c != prev_line_r) ||
            ((line_c == LINE_NOLINE) && (prev_line_r == LINE_NOLINE)) || resend_c;
    code1 = ((reps_c > cfg.shutdown_after) && resend_c) ? CODE_SHUTDOWN : line_code(line_c);
    rep2  = (line_c == LINE_ONHOOK) && (prev_line_r == LINE_ONHOOK) &&
            (reps_c <= REPEAT_LIMIT);
    stop2 = (reps_c > cfg.shutdown_after);
    code2 = stop2 ? CODE_SHUTDOWN : CODE_ONHOOK;

    q_rec = '0;
    q_rec.ring_up = ring_c;
    q_rec.avg     = avg_c;
    q_rec.code0   = CODE_ONHOOK;
    q_rec.code1   = CODE_ONHOOK;
    if (!in_bus.line_pin) begin
      q_rec.valid0 = !rung_r;
      q_rec.code0  = rung_r ? CODE_ONHOOK : CODE_RINGING;
    end else if (rep1) begin
      q_rec.valid0 = 1'b1;
      q_rec.code0  = code1;
      q_rec.two    = rep2;
      q_rec.code1  = code2;
      q_rec.stop1  = stop2;
    end else if (rep2) begin
      q_rec.valid0 = 1'b1;
      q_rec.code0  = code2;
      q_rec.stop0  = stop2;
    end

    q_push = acc && wend;

    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    low_nxt       = low_r;
    rise_nxt      = rise_r;
    prev_avg_nxt  = prev_avg_r;
    line_nxt      = line_r;
    prev_line_nxt = prev_line_r;
    reps_nxt      = reps_r;
    rung_nxt      = rung_r;
    resend_nxt    = resend_r;
    if (acc) begin
      idx_nxt    = idx_r + {{(IDX_W-1){1'b0}}, 1'b1};
      resend_nxt = resend_c;
      if (!wend) begin
        sum_nxt  = sum_c;
        low_nxt  = low_c;
        rise_nxt = rise_c;
      end else begin
        sum_nxt  = '0;
        low_nxt  = 1'b0;
        rise_nxt = 2'd0;
        if (!in_bus.line_pin) begin
          reps_nxt = '0;
          rung_nxt = 1'b1;
        end else begin
          prev_avg_nxt  = avg_c;
          line_nxt      = line_c;
          prev_line_nxt = line_c;
          reps_nxt      = reps_c + {{(REPS_W-1){1'b0}}, rep2};
          rung_nxt      = 1'b0;
          resend_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sum_r       <= '0;
      low_r       <= 1'b0;
      rise_r      <= 2'd0;
      prev_avg_r  <= '0;
      line_r      <= LINE_NOLINE;
      prev_line_r <= LINE_NOLINE;
      reps_r      <= '0;
      rung_r      <= 1'b0;
      resend_r    <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      low_r       <= low_nxt;
      rise_r      <= rise_nxt;
      prev_avg_r  <= prev_avg_nxt;
      line_r      <= line_nxt;
      prev_line_r <= prev_line_nxt;
      reps_r      <= reps_nxt;
      rung_r      <= rung_nxt;
      resend_r    <= resend_nxt;
    end
  end

endmodule

/* rtl/core/pld_queue.sv */
// ----------------------------------------------------------------------------
// pld_queue
// Short record queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module pld_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pld_pkg::rec_t wr_rec,
  input  logic          pop,
  output pld_pkg::rec_t head,
  output logic          full,
  output logic          empty
);
  import pld_pkg::*;

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/pld_back.sv */
// ----------------------------------------------------------------------------
// pld_back
// Unpacks window-end records into result beats through an output register.
// ----------------------------------------------------------------------------
module pld_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pld_pkg::rec_t head,
  input  logic          empty,
  output logic          pop,
  pld_out_if.source     out_bus
);
  import pld_pkg::*;

  logic       valid_r, valid_nxt;
  logic       phase_r, phase_nxt;
  logic       mv_r, mv_nxt;
  msg_code_t  code_r, code_nxt;
  logic       stop_r, stop_nxt;
  logic       ring_r, ring_nxt;
  logic [7:0] avg_r, avg_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    mv_nxt    = mv_r;
    code_nxt  = code_r;
    stop_nxt  = stop_r;
    ring_nxt  = ring_r;
    avg_nxt   = avg_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        ring_nxt = head.ring_up;
        avg_nxt  = head.avg;
        if (!phase_r) begin
          mv_nxt    = head.valid0;
          code_nxt  = head.code0;
          stop_nxt  = head.stop0;
          last_nxt  = !head.two;
          phase_nxt = head.two;
          pop       = !head.two;
        end else begin
          mv_nxt    = 1'b1;
          code_nxt  = head.code1;
          stop_nxt  = head.stop1;
          last_nxt  = 1'b1;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r   <= mv_nxt;
    code_r <= code_nxt;
    stop_r <= stop_nxt;
    ring_r <= ring_nxt;
    avg_r  <= avg_nxt;
    last_r <= last_nxt;
  end

  assign out_bus.valid          = valid_r;
  assign out_bus.msg_valid      = mv_r;
  assign out_bus.msg_code       = code_r;
  assign out_bus.voice_stop     = stop_r;
  assign out_bus.ring_up        = ring_r;
  assign out_bus.window_average = avg_r;
  assign out_bus.last           = last_r;

endmodule

/* rtl/core/phone_line_state_detector.sv */
// ----------------------------------------------------------------------------
// phone_line_state_detector
// Windowed line-voltage classifier issuing hook, line and ringing reports.
// ----------------------------------------------------------------------------
// One sample beat is taken per cycle. Samples mid-window give no result; the
// sixteenth sample of a window gives one or two result beats, the last one
// flagged by last. The classifier hands each window-end record to a two-entry
// queue, and the result sequencer drains it at one beat per cycle while the
// output accepts beats. Input stalls whenever the queue is full, mid-window
// samples included. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle; the user must ensure this, as the block does not.
module phone_line_state_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pld_in_if.sink                               in_bus,
  pld_out_if.source                            out_bus,
  input  logic                                 cfg_we,
  input  logic [pld_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pld_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pld_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  rec_t q_rec, q_head;
  logic q_push, q_pop, q_full, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ONHOOK_LEVEL:       cfg_nxt.onhook_level       = cfg_data;
        CFG_ONHOOK_PREV_LEVEL:  cfg_nxt.onhook_prev_level  = cfg_data;
        CFG_NOLINE_LEVEL:       cfg_nxt.noline_level       = cfg_data;
        CFG_OFFHOOK_UPPER:      cfg_nxt.offhook_upper      = cfg_data;
        CFG_OFFHOOK_PREV_LEVEL: cfg_nxt.offhook_prev_level = cfg_data;
        CFG_SWING_HIGH:         cfg_nxt.swing_high         = cfg_data;
        CFG_SWING_LOW:          cfg_nxt.swing_low          = cfg_data;
        CFG_SHUTDOWN_AFTER:     cfg_nxt.shutdown_after     = cfg_data[REPS_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.onhook_level       <= 8'd180;
      cfg_r.onhook_prev_level  <= 8'd170;
      cfg_r.noline_level       <= 8'd135;
      cfg_r.offhook_upper      <= 8'd152;
      cfg_r.offhook_prev_level <= 8'd132;
      cfg_r.swing_high         <= 8'd175;
      cfg_r.swing_low          <= 8'd40;
      cfg_r.shutdown_after     <= 5'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pld_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (q_rec)
  );

  pld_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (q_rec),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  pld_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .empty   (q_empty),
    .pop     (q_pop),
    .out_bus (out_bus)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("record pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("record popped from empty queue");

  a_stop_is_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.voice_stop) |->
      (out_bus.msg_valid && (out_bus.msg_code == CODE_SHUTDOWN)))
    else $error("voice stop without shutdown report");

  a_empty_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.msg_valid) |-> out_bus.last)
    else $error("beat without report not marked last");

endmodule
